FILE: rtl/cmbt_pkg.sv
// Shared types, constants and decode helpers of the console memory bus with timer.
package cmbt_pkg;

   localparam int VideoRamBytes = 8192;
   localparam int WorkRamBytes  = 8192;
   localparam int SpriteBytes   = 160;
   localparam int IoBytes       = 128;
   localparam int HighRamBytes  = 127;
   localparam int MaxTickCycles = 255;
   localparam int ClearLast     = 8191;

   localparam logic [7:0] FlagsReset   = 8'hE1;
   localparam logic [7:0] FlagsHigh    = 8'hE0;
   localparam logic [7:0] PadReset     = 8'h30;
   localparam logic [7:0] PadMask      = 8'h30;
   localparam logic [7:0] OpenBus      = 8'hFF;
   localparam logic [7:0] CounterTop   = 8'hFF;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_IRQ   = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      RGN_CART, RGN_VRAM, RGN_WRAM, RGN_OAM, RGN_GAP, RGN_PAD, RGN_DIV,
      RGN_TIMA, RGN_TMA, RGN_TAC, RGN_FLAGS, RGN_IO, RGN_HRAM, RGN_IE
   } region_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_TIMER, ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  tick_cycles;
      logic [2:0]  irq_bit;
      logic [7:0]  buttons;
      logic [7:0]  cart_read_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        cart_write_strobe;
      logic [15:0] cart_address;
      logic [7:0]  cart_value;
      logic [7:0]  interrupt_flags;
      logic [7:0]  interrupt_mask;
   } rsp_payload_type;

   function automatic region_type decode_region(input logic [15:0] a);
      region_type r;
      if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) r = RGN_CART;
      else if (a <= 16'h9FFF) r = RGN_VRAM;
      else if (a <= 16'hFDFF) r = RGN_WRAM;
      else if (a <= 16'hFE9F) r = RGN_OAM;
      else if (a <= 16'hFEFF) r = RGN_GAP;
      else if (a == 16'hFF00) r = RGN_PAD;
      else if (a == 16'hFF04) r = RGN_DIV;
      else if (a == 16'hFF05) r = RGN_TIMA;
      else if (a == 16'hFF06) r = RGN_TMA;
      else if (a == 16'hFF07) r = RGN_TAC;
      else if (a == 16'hFF0F) r = RGN_FLAGS;
      else if (a == 16'hFFFF) r = RGN_IE;
      else if (a <= 16'hFF7F) r = RGN_IO;
      else r = RGN_HRAM;
      return r;
   endfunction

   function automatic logic [15:0] prescale_limit(input logic [1:0] sel);
      logic [15:0] l;
      case (sel)
         2'd0:    l = 16'd1024;
         2'd1:    l = 16'd16;
         2'd2:    l = 16'd64;
         default: l = 16'd256;
      endcase
      return l;
   endfunction

endpackage

FILE: rtl/cmbt_if.sv
// Valid/ready channel interfaces for requests and responses.
interface cmbt_req_if import cmbt_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cmbt_rsp_if import cmbt_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/cmbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/console_memory_bus_with_timer.sv
// Top level: address decode, memories, I/O registers and iterative timer.
// After reset the block sweeps all memories to zero, one address per cycle,
// over addresses 0 to 8191 before it takes its first request. A write or
// interrupt request then goes to the finish state, a read first passes the
// read state for the registered memory read. A tick with the timer stopped goes
// to the finish state; with the timer running it stays in the timer state while
// a prescale threshold is crossed, as one subtract-and-compare unit handles one
// threshold per cycle. The response waits in an output register until it is taken.
module console_memory_bus_with_timer import cmbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   cmbt_req_if.sink   req_if,
   cmbt_rsp_if.source rsp_if
);
   state_type       state_ff, state_in;
   logic [12:0]     clear_ff, clear_in;
   logic            cart_present_ff;
   req_payload_type req_ff;
   region_type      region_ff;
   logic [7:0]      read_data_ff, read_data_in;
   logic            strobe_ff;
   logic [7:0]      ie_ff, flags_ff, pad_ff, tima_ff, tma_ff;
   logic [2:0]      tac_ff;
   logic [15:0]     div_ff, pre_ff;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   logic            accept, clearing, do_write, rsp_free, pass, load_rsp;
   region_type      region_in;
   logic [7:0]      cycles, wdata;
   logic [15:0]     limit;
   logic [7:0]      vram_q, wram_q, oam_q, io_q, hram_q, pad_q;

   assign clearing = (state_ff == ST_CLEAR);
   assign accept   = req_if.valid && req_if.ready;
   assign region_in = decode_region(req_if.payload.address);
   assign do_write = accept && (req_kind_type'(req_if.payload.req_type) == REQ_WRITE);
   assign wdata    = clearing ? 8'd0 : req_if.payload.write_data;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign cycles   = (req_if.payload.tick_cycles > 8'(MaxTickCycles)) ?
                     8'(MaxTickCycles) : req_if.payload.tick_cycles;
   assign limit    = prescale_limit(tac_ff[1:0]);
   assign pass     = (pre_ff >= limit);
   assign req_if.ready = (state_ff == ST_IDLE);

   cmbt_ram #(.WIDTH(8), .DEPTH(VideoRamBytes)) u_vram (
      .clock, .we(clearing || (do_write && region_in == RGN_VRAM)),
      .waddr(clearing ? clear_ff : req_if.payload.address[12:0]), .wdata,
      .raddr(req_if.payload.address[12:0]), .rdata(vram_q));

   cmbt_ram #(.WIDTH(8), .DEPTH(WorkRamBytes)) u_wram (
      .clock, .we(clearing || (do_write && region_in == RGN_WRAM)),
      .waddr(clearing ? clear_ff : req_if.payload.address[12:0]), .wdata,
      .raddr(req_if.payload.address[12:0]), .rdata(wram_q));

   cmbt_ram #(.WIDTH(8), .DEPTH(SpriteBytes)) u_oam (
      .clock,
      .we((clearing && clear_ff < 13'(SpriteBytes)) || (do_write && region_in == RGN_OAM)),
      .waddr(clearing ? clear_ff[7:0] : req_if.payload.address[7:0]), .wdata,
      .raddr(req_if.payload.address[7:0]), .rdata(oam_q));

   cmbt_ram #(.WIDTH(8), .DEPTH(IoBytes)) u_io (
      .clock,
      .we((clearing && clear_ff < 13'(IoBytes)) || (do_write && region_in == RGN_IO)),
      .waddr(clearing ? clear_ff[6:0] : req_if.payload.address[6:0]), .wdata,
      .raddr(req_if.payload.address[6:0]), .rdata(io_q));

   cmbt_ram #(.WIDTH(8), .DEPTH(HighRamBytes)) u_hram (
      .clock,
      .we((clearing && clear_ff < 13'(HighRamBytes)) || (do_write && region_in == RGN_HRAM)),
      .waddr(clearing ? clear_ff[6:0] : req_if.payload.address[6:0]), .wdata,
      .raddr(req_if.payload.address[6:0]), .rdata(hram_q));

   always_comb begin
      if (!pad_ff[4]) begin
         pad_q = (pad_ff & 8'hF0) | {4'd0, req_ff.buttons[3:0]};
      end else if (!pad_ff[5]) begin
         pad_q = (pad_ff & 8'hF0) | {4'd0, req_ff.buttons[7:4]};
      end else begin
         pad_q = pad_ff | 8'h0F;
      end
   end

   always_comb begin
      case (region_ff)
         RGN_CART:  read_data_in = cart_present_ff ? req_ff.cart_read_data : OpenBus;
         RGN_VRAM:  read_data_in = vram_q;
         RGN_WRAM:  read_data_in = wram_q;
         RGN_OAM:   read_data_in = oam_q;
         RGN_GAP:   read_data_in = OpenBus;
         RGN_PAD:   read_data_in = pad_q;
         RGN_DIV:   read_data_in = div_ff[15:8];
         RGN_TIMA:  read_data_in = tima_ff;
         RGN_TMA:   read_data_in = tma_ff;
         RGN_TAC:   read_data_in = {5'd0, tac_ff};
         RGN_FLAGS: read_data_in = flags_ff | FlagsHigh;
         RGN_IE:    read_data_in = ie_ff;
         RGN_IO:    read_data_in = io_q;
         default:   read_data_in = hram_q;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 13'd1;
            if (clear_ff == 13'(ClearLast)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind_type'(req_if.payload.req_type))
                  REQ_READ: state_in = ST_READ;
                  REQ_TICK: state_in = tac_ff[2] ? ST_TIMER : ST_FINISH;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ:  state_in = ST_FINISH;
         ST_TIMER: begin
            if (!pass) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_ff        <= '0;
         cart_present_ff <= 1'b0;
         ie_ff           <= '0;
         flags_ff        <= FlagsReset;
         pad_ff          <= PadReset;
         tima_ff         <= '0;
         tma_ff          <= '0;
         tac_ff          <= '0;
         div_ff          <= '0;
         pre_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         if (csr_write_enable) cart_present_ff <= csr_write_data;
         if (accept) begin
            case (req_kind_type'(req_if.payload.req_type))
               REQ_WRITE: begin
                  case (region_in)
                     RGN_PAD:   pad_ff   <= req_if.payload.write_data & PadMask;
                     RGN_DIV:   div_ff   <= '0;
                     RGN_TIMA:  tima_ff  <= req_if.payload.write_data;
                     RGN_TMA:   tma_ff   <= req_if.payload.write_data;
                     RGN_TAC:   tac_ff   <= req_if.payload.write_data[2:0];
                     RGN_FLAGS: flags_ff <= req_if.payload.write_data | FlagsHigh;
                     RGN_IE:    ie_ff    <= req_if.payload.write_data;
                     default: ;
                  endcase
               end
               REQ_TICK: begin
                  div_ff <= div_ff + {8'd0, cycles};
                  if (tac_ff[2]) pre_ff <= pre_ff + {8'd0, cycles};
               end
               REQ_IRQ: flags_ff <= flags_ff | (8'd1 << req_if.payload.irq_bit);
               default: ;
            endcase
         end
         // one prescale threshold per cycle
         if (state_ff == ST_TIMER && pass) begin
            pre_ff <= pre_ff - limit;
            if (tima_ff == CounterTop) begin
               tima_ff  <= tma_ff;
               flags_ff <= flags_ff | 8'h04;
            end else begin
               tima_ff <= tima_ff + 8'd1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff       <= req_if.payload;
         region_ff    <= region_in;
         read_data_ff <= '0;
         strobe_ff    <= (req_kind_type'(req_if.payload.req_type) == REQ_WRITE)
                         && (region_in == RGN_CART) && cart_present_ff;
      end
      if (state_ff == ST_READ) read_data_ff <= read_data_in;
      if (load_rsp) begin
         rsp_ff.read_data         <= read_data_ff;
         rsp_ff.cart_write_strobe <= strobe_ff;
         rsp_ff.cart_address      <= strobe_ff ? req_ff.address : 16'd0;
         rsp_ff.cart_value        <= strobe_ff ? req_ff.write_data : 8'd0;
         rsp_ff.interrupt_flags   <= flags_ff;
         rsp_ff.interrupt_mask    <= ie_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;
endmodule
